@@ hw/rtl/deadline_timer_queue_defines.svh @@
// Assertion macros for the deadline timer queue.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define DTQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
// cond must never be true outside reset
`define DTQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");
`else
`define DTQ_ASSERT(lbl, clk, rst_n, prop)
`define DTQ_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ hw/rtl/dtq_pkg.sv @@
package dtq_pkg;

  localparam int SLOTS     = 16;
  // slot_id is 4 bits wide, so at most 16 slots are reachable
  localparam int TBL_SLOTS = (SLOTS < 16) ? SLOTS : 16;
  localparam int IDX_W     = (TBL_SLOTS > 1) ? $clog2(TBL_SLOTS) : 1;
  localparam int CNT_W     = $clog2(TBL_SLOTS + 1);
  localparam int TIME_W    = 64;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_ERASE  = 3'd2,
    ACT_BEAT   = 3'd3,
    ACT_CLEAR  = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REJECT  = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]               action;
    logic [3:0]               slot_id;
    logic signed [TIME_W-1:0] time_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired_valid;
    logic [3:0] fired_slot;
    logic       last;
    logic [4:0] armed_count;
  } out_word_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_DECIDE,
    CTL_SCAN,
    CTL_POST
  } ctl_state_e;

  typedef struct packed {
    logic capture;     // latch the accepted word
    logic scan_start;  // restart the slot walk
    logic scan_step;   // issue reads during the walk
    logic commit;      // apply action, write result word
  } dp_cmd_t;

  typedef struct packed {
    logic needs_scan;  // captured action must walk the table
    logic scan_done;   // last slot has passed the compare stages
    logic more;        // beat has further expired slots to report
    logic out_free;    // output register can take a word now
  } dp_stat_t;

endpackage

@@ hw/rtl/dtq_ram.sv @@
module dtq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dtq_ctrl.sv @@
module dtq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtq_pkg::dp_stat_t stat_i,
  output dtq_pkg::dp_cmd_t  cmd_o
);

  dtq_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dtq_pkg::CTL_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = dtq_pkg::CTL_DECIDE;
        end
      end
      dtq_pkg::CTL_DECIDE: begin
        if (stat_i.needs_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = dtq_pkg::CTL_SCAN;
        end else begin
          state_d = dtq_pkg::CTL_POST;
        end
      end
      dtq_pkg::CTL_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = dtq_pkg::CTL_POST;
        end
      end
      dtq_pkg::CTL_POST: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          if (stat_i.more) begin
            cmd_o.scan_start = 1'b1;
            state_d          = dtq_pkg::CTL_SCAN;
          end else begin
            state_d = dtq_pkg::CTL_IDLE;
          end
        end
      end
      default: begin
        state_d = dtq_pkg::CTL_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/dtq_datapath.sv @@
module dtq_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtq_pkg::in_word_t  in_word_i,
  input  dtq_pkg::dp_cmd_t   cmd_i,
  output dtq_pkg::dp_stat_t  stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output dtq_pkg::out_word_t out_word_o
);

  localparam int IW = dtq_pkg::IDX_W;
  localparam int CW = dtq_pkg::CNT_W;
  localparam int TW = dtq_pkg::TIME_W;

  // captured word
  logic [2:0]           act_q;
  logic [3:0]           slot_q;
  logic signed [TW-1:0] time_q;

  // timer state
  logic [dtq_pkg::TBL_SLOTS-1:0] armed_q, armed_d;
  logic [CW-1:0]                 count_q, count_d;

  // walk: address, ram read stage, compare stage
  logic [CW-1:0]        addr_q;
  logic                 rd_vld_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 s2_vld_q, s2_cand_q;
  logic [IW-1:0]        s2_idx_q;
  logic signed [TW-1:0] s2_data_q;

  // walk results
  logic                 found_q;
  logic [CW-1:0]        cand_cnt_q;
  logic signed [TW-1:0] best_q;
  logic [IW-1:0]        best_idx_q;
  logic signed [TW-1:0] prev_q;
  logic                 have_prev_q;

  // output register
  logic               out_valid_q;
  dtq_pkg::out_word_t out_q, res;

  logic                 issue, slot_ok, is_beat, cand, ins_ok, we;
  logic [IW-1:0]        sidx;
  logic signed [TW-1:0] rdata;

  assign sidx    = slot_q[IW-1:0];
  assign slot_ok = ({1'b0, slot_q} < 5'(dtq_pkg::TBL_SLOTS));
  assign is_beat = (act_q == dtq_pkg::ACT_BEAT);
  assign issue   = cmd_i.scan_step && (addr_q != CW'(dtq_pkg::TBL_SLOTS));
  assign ins_ok  = slot_ok && !armed_q[sidx] && !found_q;

  dtq_ram #(
    .WIDTH (TW),
    .DEPTH (dtq_pkg::TBL_SLOTS)
  ) u_deadlines (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (sidx),
    .wdata_i (time_q),
    .re_i    (issue),
    .raddr_i (addr_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // stage A: eligibility of the slot just read
  always_comb begin
    if (is_beat) begin
      cand = !(time_q < rdata) && (!have_prev_q || (rdata > prev_q));
    end else begin
      cand = (rdata == time_q);
    end
    cand = cand && rd_vld_q && armed_q[rd_idx_q];
  end

  // result word and state update for the captured action
  always_comb begin
    res         = '0;
    res.last    = 1'b1;
    res.status  = dtq_pkg::ST_MISSING;
    armed_d     = armed_q;
    count_d     = count_q;
    we          = 1'b0;
    case (act_q)
      dtq_pkg::ACT_INSERT: begin
        if (!slot_ok) begin
          res.status = dtq_pkg::ST_MISSING;
        end else if (!ins_ok) begin
          res.status = dtq_pkg::ST_REJECT;
        end else begin
          res.status    = dtq_pkg::ST_DONE;
          we            = cmd_i.commit;
          armed_d[sidx] = 1'b1;
          count_d       = count_q + CW'(1);
        end
      end
      dtq_pkg::ACT_REMOVE: begin
        if (slot_ok && armed_q[sidx]) begin
          res.status    = dtq_pkg::ST_DONE;
          armed_d[sidx] = 1'b0;
          count_d       = count_q - CW'(1);
        end
      end
      dtq_pkg::ACT_ERASE: begin
        if (found_q) begin
          res.status          = dtq_pkg::ST_DONE;
          armed_d[best_idx_q] = 1'b0;
          count_d             = count_q - CW'(1);
        end
      end
      dtq_pkg::ACT_BEAT: begin
        res.status = dtq_pkg::ST_DONE;
        if (found_q) begin
          res.fired_valid = 1'b1;
          res.fired_slot  = 4'(best_idx_q);
          res.last        = (cand_cnt_q == CW'(1));
        end
      end
      dtq_pkg::ACT_CLEAR: begin
        res.status = dtq_pkg::ST_DONE;
        armed_d    = '0;
        count_d    = '0;
      end
      default: begin
        res.status = dtq_pkg::ST_MISSING;
      end
    endcase
    res.armed_count = 5'(count_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      count_q     <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      cand_cnt_q  <= '0;
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        addr_q     <= '0;
        rd_vld_q   <= 1'b0;
        s2_vld_q   <= 1'b0;
        found_q    <= 1'b0;
        cand_cnt_q <= '0;
      end else begin
        if (issue) begin
          addr_q <= addr_q + CW'(1);
        end
        rd_vld_q <= issue;
        s2_vld_q <= rd_vld_q;
        if (s2_vld_q && s2_cand_q) begin
          found_q    <= 1'b1;
          cand_cnt_q <= cand_cnt_q + CW'(1);
        end
      end
      if (cmd_i.capture) begin
        have_prev_q <= 1'b0;
      end else if (cmd_i.commit && is_beat && found_q) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        armed_q     <= armed_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= in_word_i.action;
      slot_q <= in_word_i.slot_id;
      time_q <= in_word_i.time_value;
    end
    rd_idx_q  <= addr_q[IW-1:0];
    s2_cand_q <= cand;
    s2_idx_q  <= rd_idx_q;
    s2_data_q <= rdata;
    if (s2_vld_q && s2_cand_q && (!found_q || (s2_data_q < best_q))) begin
      best_q     <= s2_data_q;
      best_idx_q <= s2_idx_q;
    end
    if (cmd_i.commit && is_beat && found_q) begin
      prev_q <= best_q;
    end
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign stat_o.needs_scan = ((act_q == dtq_pkg::ACT_INSERT) && slot_ok && !armed_q[sidx])
                             || (act_q == dtq_pkg::ACT_ERASE) || is_beat;
  assign stat_o.scan_done  = s2_vld_q && (s2_idx_q == IW'(dtq_pkg::TBL_SLOTS - 1));
  assign stat_o.more       = is_beat && found_q && (cand_cnt_q > CW'(1));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hw/rtl/deadline_timer_queue.sv @@
// Deadline timer queue: 16 timer slots, one word in, one or more words out.
// Remove, clear, unknown actions and inserts to an armed or out-of-range slot commit
// without a walk; other inserts, erase and beat walk all slots first. A beat then
// walks again once per further expired slot, one word per walk. One word in service;
// the next word can be accepted in the cycle after the last commit.
// Reset: all slots disarmed, count zero; deadline memory is not cleared.
`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dtq_pkg::out_word_t out_word_o
);

  // Controller sequences each word: capture, optional slot walk, commit.
  // A beat repeats the walk once per expired slot, each walk picking the
  // smallest deadline above the one reported before, so words come out in
  // ascending deadline order. The walk also counts remaining candidates so
  // the final word knows it is last.
  dtq_pkg::dp_cmd_t  cmd;
  dtq_pkg::dp_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath holds the armed flags, the deadline memory, the two-stage
  // compare pipeline of the walk and the output register. The output
  // register lets a new word be accepted while the last result waits.
  dtq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  // A result is only written when the output register can take it.
  `DTQ_ASSERT_NEVER(a_commit_needs_room, clk_i, rst_ni, cmd.commit && !stat.out_free)

  // In the cycle after accepting a word the block is busy.
  `DTQ_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // A fired slot is always reported with status done.
  `DTQ_ASSERT(a_fired_done, clk_i, rst_ni, (out_valid_o && out_word_o.fired_valid) |-> (out_word_o.status == dtq_pkg::ST_DONE))

  // The armed count never exceeds the table size.
  `DTQ_ASSERT(a_count_bound, clk_i, rst_ni, out_valid_o |-> (out_word_o.armed_count <= 5'(dtq_pkg::TBL_SLOTS)))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import dtq_pkg::*;

  // action codes the block does not know; it answers them with ST_MISSING
  localparam logic [2:0] ACT_UNDEF_A = 3'd5;
  localparam logic [2:0] ACT_UNDEF_B = 3'd6;
  localparam logic [2:0] ACT_UNDEF_C = 3'd7;

  localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

  localparam int CYCLE_LIMIT = 1_000_000;
  // one full slot walk per reported slot, 16 slots at most, plus margin
  localparam int TAIL_CYCLES = 25 * TBL_SLOTS;
  localparam int RAND_PER_PHASE = 62;
  localparam int DIR_ROWS = 24;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  deadline_timer_queue uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Shadow copy of the timer table; updated at each accepted input word.
  // ---------------------------------------------------------------------
  logic signed [63:0] tq_deadline [TBL_SLOTS];
  logic [15:0]        tq_armed = '0;
  logic [4:0]         tq_count = '0;

  out_word_t timer_expect[$];   // result words still owed by the block

  int send_gap_pct = 0;         // chance the sender idles in a cycle
  int recv_stall_pct = 0;       // chance the receiver stalls in a cycle
  int words_sent = 0;
  int results_seen = 0;
  int fired_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  out_word_t head_word;

  // Apply one input word to the shadow table. With keep set, its result
  // words are queued as expectations; otherwise only the state moves.
  task automatic predict_timer_action(input in_word_t w, input bit keep);
    out_word_t          res;
    logic [15:0]        due;
    logic signed [63:0] now;
    int                 pick;
    bit                 dup;
    begin
      res = '0;
      res.last = 1'b1;
      now = w.time_value;
      case (w.action)
        ACT_INSERT: begin
          dup = 1'b0;
          for (int i = 0; i < TBL_SLOTS; i++)
            if (tq_armed[i] && tq_deadline[i] == now) dup = 1'b1;
          if (w.slot_id >= TBL_SLOTS) begin
            res.status = ST_MISSING;
          end else if (tq_armed[w.slot_id] || dup) begin
            res.status = ST_REJECT;
          end else begin
            res.status = ST_DONE;
            tq_deadline[w.slot_id] = now;
            tq_armed[w.slot_id] = 1'b1;
            tq_count++;
          end
        end
        ACT_REMOVE: begin
          res.status = ST_MISSING;
          if (w.slot_id < TBL_SLOTS && tq_armed[w.slot_id]) begin
            tq_armed[w.slot_id] = 1'b0;
            tq_count--;
            res.status = ST_DONE;
          end
        end
        ACT_ERASE: begin
          res.status = ST_MISSING;
          // armed deadlines are unique, so at most one slot matches
          for (int i = 0; i < TBL_SLOTS; i++) begin
            if (tq_armed[i] && tq_deadline[i] == now) begin
              tq_armed[i] = 1'b0;
              tq_count--;
              res.status = ST_DONE;
            end
          end
        end
        ACT_BEAT: begin
          res.status = ST_DONE;
          due = '0;
          for (int i = 0; i < TBL_SLOTS; i++)
            if (tq_armed[i] && tq_deadline[i] <= now) due[i] = 1'b1;
          // report expired slots earliest deadline first, one word each
          while (due != '0) begin
            pick = -1;
            for (int i = 0; i < TBL_SLOTS; i++)
              if (due[i] && (pick < 0 || tq_deadline[i] < tq_deadline[pick])) pick = i;
            due[pick] = 1'b0;
            res.fired_valid = 1'b1;
            res.fired_slot = pick[3:0];
            res.last = (due == '0);
            res.armed_count = tq_count;
            if (keep) timer_expect.push_back(res);
          end
        end
        ACT_CLEAR: begin
          res.status = ST_DONE;
          tq_armed = '0;
          tq_count = '0;
        end
        default: res.status = ST_MISSING;
      endcase
      res.armed_count = tq_count;
      // beats that fired have queued their words already
      if (keep && !res.fired_valid) timer_expect.push_back(res);
    end
  endtask

  // Deadline pool: clustered small values for collisions and ordering,
  // plus full-range values and both ends of the signed range.
  function automatic logic signed [63:0] pick_time();
    logic signed [63:0] t;
    int                 r;
    begin
      r = $urandom_range(99);
      if (r < 50) begin
        t = $urandom_range(100);
        t = t - 64'sd50;
      end else if (r < 70) begin
        t = {$urandom, $urandom};
      end else if (r < 85) begin
        t = T_MIN + $urandom_range(20);
      end else begin
        t = T_MAX - $urandom_range(20);
      end
      return t;
    end
  endfunction

  // Deadline of some armed slot, so erase/beat/duplicate insert hit.
  function automatic logic signed [63:0] armed_time();
    int first;
    int idx;
    begin
      first = $urandom_range(TBL_SLOTS - 1);
      for (int k = 0; k < TBL_SLOTS; k++) begin
        idx = (first + k) % TBL_SLOTS;
        if (tq_armed[idx]) return tq_deadline[idx];
      end
      return pick_time();
    end
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       r;
    begin
      w = '0;
      w.slot_id = 4'($urandom_range(15));
      w.time_value = pick_time();
      r = $urandom_range(99);
      if (r < 40) begin
        w.action = ACT_INSERT;
        if ($urandom_range(99) < 20) w.time_value = armed_time();
      end else if (r < 55) begin
        w.action = ACT_BEAT;
        if ($urandom_range(1) == 0) w.time_value = armed_time();
      end else if (r < 68) begin
        w.action = ACT_REMOVE;
      end else if (r < 80) begin
        w.action = ACT_ERASE;
        if ($urandom_range(99) < 60) w.time_value = armed_time();
      end else if (r < 84) begin
        w.action = ACT_CLEAR;
      end else if (r < 88) begin
        w.action = 3'($urandom_range(ACT_UNDEF_A, ACT_UNDEF_C));
      end else begin
        w.action = ACT_INSERT;
      end
      return w;
    end
  endfunction

  // Called and returns just after a falling edge. Valid stays high into
  // the next word when no gap is drawn, so it is never dropped and raised
  // within one step.
  task automatic issue_word(input in_word_t w, input bit typed, input out_word_t want);
    begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_word_i <= w;
      do @(posedge clk_i); while (!in_ready_o);
      words_sent++;
      predict_timer_action(w, !typed);
      if (typed) timer_expect.push_back(want);
      @(negedge clk_i);
    end
  endtask

  // Hold the sender off until every owed word has come back.
  task automatic drain_results();
    begin
      in_valid_i <= 1'b0;
      while (timer_expect.size() != 0) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  function automatic out_word_t plain_word(status_e st, int cnt);
    out_word_t w;
    begin
      w = '0;
      w.status = st;
      w.last = 1'b1;
      w.armed_count = 5'(cnt);
      return w;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side: ready toggles at the falling edge, checked at rising.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (out_word_o.fired_valid) fired_seen++;
      if (timer_expect.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word st=%0d fv=%0d slot=%0d last=%0d cnt=%0d",
                 $time, out_word_o.status, out_word_o.fired_valid,
                 out_word_o.fired_slot, out_word_o.last, out_word_o.armed_count);
      end else begin
        head_word = timer_expect.pop_front();
        if (out_word_o !== head_word) begin
          mismatches++;
          $display("%0t: mismatch expected st=%0d fv=%0d slot=%0d last=%0d cnt=%0d",
                   $time, head_word.status, head_word.fired_valid,
                   head_word.fired_slot, head_word.last, head_word.armed_count);
          $display("%0t:          actual   st=%0d fv=%0d slot=%0d last=%0d cnt=%0d",
                   $time, out_word_o.status, out_word_o.fired_valid,
                   out_word_o.fired_slot, out_word_o.last, out_word_o.armed_count);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed rows: typed rows carry the answer, the rest use the shadow.
  // ---------------------------------------------------------------------
  typedef struct {
    logic [2:0]         act;
    logic [3:0]         slot;
    logic signed [63:0] tv;
    bit                 typed;
    out_word_t          want;
  } dir_row_t;

  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    in_word_t w;

    // empty table: every lookup misses, beat and clear are quiet
    dir_rows[0]  = '{ACT_REMOVE,  4'd0,  64'sd0,  1'b1, plain_word(ST_MISSING, 0)};
    dir_rows[1]  = '{ACT_ERASE,   4'd0,  64'sd0,  1'b1, plain_word(ST_MISSING, 0)};
    dir_rows[2]  = '{ACT_BEAT,    4'd0,  T_MAX,   1'b1, plain_word(ST_DONE, 0)};
    dir_rows[3]  = '{ACT_CLEAR,   4'd0,  64'sd0,  1'b1, plain_word(ST_DONE, 0)};
    dir_rows[4]  = '{ACT_UNDEF_A, 4'd0,  64'sd0,  1'b1, plain_word(ST_MISSING, 0)};
    dir_rows[5]  = '{ACT_UNDEF_B, 4'd15, T_MAX,   1'b1, plain_word(ST_MISSING, 0)};
    dir_rows[6]  = '{ACT_UNDEF_C, 4'd9,  T_MIN,   1'b1, plain_word(ST_MISSING, 0)};
    // fill at both ends of the range and both ends of the slot index
    dir_rows[7]  = '{ACT_INSERT,  4'd0,  T_MIN,   1'b1, plain_word(ST_DONE, 1)};
    dir_rows[8]  = '{ACT_INSERT,  4'd15, T_MAX,   1'b1, plain_word(ST_DONE, 2)};
    // armed slot, then duplicate deadline: both rejected, nothing moves
    dir_rows[9]  = '{ACT_INSERT,  4'd0,  64'sd5,  1'b1, plain_word(ST_REJECT, 2)};
    dir_rows[10] = '{ACT_INSERT,  4'd7,  T_MAX,   1'b1, plain_word(ST_REJECT, 2)};
    dir_rows[11] = '{ACT_INSERT,  4'd7,  -64'sd1, 1'b1, plain_word(ST_DONE, 3)};
    dir_rows[12] = '{ACT_INSERT,  4'd8,  64'sd0,  1'b1, plain_word(ST_DONE, 4)};
    // beats: partial, only the earliest (old deadline of slot 0 kept), all
    dir_rows[13] = '{ACT_BEAT,    4'd3,  -64'sd1, 1'b0, '0};
    dir_rows[14] = '{ACT_BEAT,    4'd0,  T_MIN,   1'b0, '0};
    dir_rows[15] = '{ACT_BEAT,    4'd15, T_MAX,   1'b0, '0};
    dir_rows[16] = '{ACT_ERASE,   4'd0,  64'sd123, 1'b1, plain_word(ST_MISSING, 4)};
    dir_rows[17] = '{ACT_ERASE,   4'd0,  -64'sd1, 1'b1, plain_word(ST_DONE, 3)};
    dir_rows[18] = '{ACT_REMOVE,  4'd15, 64'sd0,  1'b1, plain_word(ST_DONE, 2)};
    dir_rows[19] = '{ACT_REMOVE,  4'd15, 64'sd0,  1'b1, plain_word(ST_MISSING, 2)};
    dir_rows[20] = '{ACT_INSERT,  4'd15, 64'sd1,  1'b1, plain_word(ST_DONE, 3)};
    dir_rows[21] = '{ACT_BEAT,    4'd0,  64'sd0,  1'b0, '0};
    dir_rows[22] = '{ACT_CLEAR,   4'd0,  64'sd0,  1'b1, plain_word(ST_DONE, 0)};
    dir_rows[23] = '{ACT_BEAT,    4'd0,  T_MAX,   1'b1, plain_word(ST_DONE, 0)};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      w = '0;
      w.action = dir_rows[r].act;
      w.slot_id = dir_rows[r].slot;
      w.time_value = dir_rows[r].tv;
      issue_word(w, dir_rows[r].typed, dir_rows[r].want);
    end
    drain_results();

    // idle profiles: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = (ph == 1) ? 73 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 27 : 0;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        issue_word(random_word(), 1'b0, '0);
        if ($urandom_range(99) < 2) drain_results();
      end
      drain_results();
    end

    send_gap_pct = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d words, checked %0d result words (%0d expired-slot reports)",
             words_sent, results_seen, fired_seen);
    $display("across four idle/stall profiles; %0d mismatches", mismatches);
    if (mismatches == 0 && timer_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ deadline_timer_queue.f @@
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_ram.sv
hw/rtl/dtq_ctrl.sv
hw/rtl/dtq_datapath.sv
hw/rtl/deadline_timer_queue.sv
tb/tb.sv
